[src/cws_pkg.sv]
`default_nettype none
package cws_pkg;

  localparam int DEPTH        = 64;
  localparam int SLOT_BITS    = $clog2(DEPTH);
  localparam int COUNT_BITS   = $clog2(DEPTH + 1);
  localparam int NODE_ID_BITS = 16;
  localparam int TOTAL_BITS   = 22;
  localparam int WEIGHT_BITS  = 16;
  localparam int RAND_BITS    = 16;
  localparam int THR_BITS     = 16;
  localparam int PROD_BITS    = RAND_BITS + TOTAL_BITS;
  localparam int QUO_BITS     = TOTAL_BITS;
  localparam int PADDR_BITS   = 3;
  localparam int PDATA_BITS   = 32;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
  localparam logic [THR_BITS-1:0]   THR_RESET = 16'd63898;

  // register index within the configuration map
  localparam logic [0:0] REG_THRESHOLD = 1'b0;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_STOP  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [15:0]            neighbor_in;
    logic [WEIGHT_BITS-1:0] weight;
    logic [RAND_BITS-1:0]   random;
  } in_req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [15:0]           neighbor_out;
    logic [5:0]            slot;
    logic [TOTAL_BITS-1:0] total;
    logic [6:0]            count;
  } out_rsp_t;

endpackage
`default_nettype wire

[src/cumulative_weight_sampler_unit.sv]
`default_nettype none
// Weighted neighbor sampler over one adjacency list of up to 64 entries. Each entry
// (neighbor id and cumulative Q14.8 weight) lives in one synchronous memory with
// separate write and read ports. Clear and append requests, a stop, an empty-table
// sample and a full-table append answer from the output register in the cycle after
// acceptance. A successful sample runs these steps from acceptance to a valid result:
// the random*total multiply, a divider start, the bit-serial divide by the continue
// threshold, a memory read then a compare per binary search step (up to 6 steps with
// 64 entries), then one read of the chosen entry, a state that holds it and one that
// loads the output register once the output is free.
// One request is in flight at a time; a result waiting in a stalled output register
// holds off the next request.
module cumulative_weight_sampler_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire cws_pkg::in_req_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output cws_pkg::out_rsp_t                        out_data,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [cws_pkg::PADDR_BITS-1:0]      cfg_paddr,
  input  wire logic [cws_pkg::PDATA_BITS-1:0]      cfg_pwdata,
  output logic [cws_pkg::PDATA_BITS-1:0]           cfg_prdata,
  output logic                                     cfg_pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_SRCH   = 3'd4;
  localparam logic [2:0] ST_CMP    = 3'd5;
  localparam logic [2:0] ST_FETCH  = 3'd6;
  localparam logic [2:0] ST_RESP   = 3'd7;

  localparam logic [cws_pkg::COUNT_BITS-1:0] COUNT_FULL =
    cws_pkg::COUNT_BITS'(cws_pkg::DEPTH);

  localparam logic REG_THRESHOLD_BIT = cws_pkg::REG_THRESHOLD[0];

  typedef struct packed {
    logic [cws_pkg::TOTAL_BITS-1:0]   cum;
    logic [cws_pkg::NODE_ID_BITS-1:0] id;
  } entry_t;

  entry_t mem [cws_pkg::DEPTH];

  logic [2:0]                        state_r, state_nxt;
  logic [cws_pkg::THR_BITS-1:0]      thr_r, thr_nxt;
  logic [cws_pkg::COUNT_BITS-1:0]    count_r, count_nxt;
  logic [cws_pkg::TOTAL_BITS-1:0]    total_r, total_nxt;
  logic [cws_pkg::RAND_BITS-1:0]     rnd_r, rnd_nxt;
  logic [cws_pkg::PROD_BITS-1:0]     prod_r, prod_nxt;
  logic [cws_pkg::TOTAL_BITS-1:0]    target_r, target_nxt;
  logic [cws_pkg::SLOT_BITS-1:0]     lo_r, lo_nxt;
  logic [cws_pkg::SLOT_BITS-1:0]     hi_r, hi_nxt;
  logic                              out_valid_r, out_valid_nxt;
  cws_pkg::out_rsp_t                 out_data_r, out_data_nxt;
  entry_t                            rd_data_r;

  logic                              out_free;
  logic                              in_acc;
  logic                              cfg_wr;
  logic [cws_pkg::TOTAL_BITS:0]      sum_ext;
  logic [cws_pkg::TOTAL_BITS-1:0]    sum_sat;
  logic [cws_pkg::SLOT_BITS:0]       mid_sum;
  logic [cws_pkg::SLOT_BITS-1:0]     mid;
  logic                              mem_we;
  logic [cws_pkg::SLOT_BITS-1:0]     wr_addr;
  entry_t                            wr_entry;
  logic                              mem_re;
  logic [cws_pkg::SLOT_BITS-1:0]     rd_addr;
  logic                              div_start;
  logic                              div_done;
  logic [cws_pkg::QUO_BITS-1:0]      div_quo;

  cws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (thr_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                    (cfg_paddr[2] == REG_THRESHOLD_BIT);

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_THRESHOLD_BIT) ?
                      {{(cws_pkg::PDATA_BITS - cws_pkg::THR_BITS){1'b0}}, thr_r} : '0;

  assign sum_ext = {1'b0, total_r} +
                   {{(cws_pkg::TOTAL_BITS + 1 - cws_pkg::WEIGHT_BITS){1'b0}}, in_data.weight};
  assign sum_sat = sum_ext[cws_pkg::TOTAL_BITS] ? cws_pkg::TOTAL_MAX
                                                : sum_ext[cws_pkg::TOTAL_BITS-1:0];
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[cws_pkg::SLOT_BITS:1];

  always_comb begin
    state_nxt     = state_r;
    thr_nxt       = thr_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    rnd_nxt       = rnd_r;
    prod_nxt      = prod_r;
    target_nxt    = target_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    wr_addr       = count_r[cws_pkg::SLOT_BITS-1:0];
    wr_entry      = '{cum: sum_sat, id: in_data.neighbor_in};
    mem_re        = 1'b0;
    rd_addr       = mid;
    div_start     = 1'b0;

    if (cfg_wr) begin
      thr_nxt = cfg_pwdata[cws_pkg::THR_BITS-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: cws_pkg::STATUS_OK, neighbor_out: '0, slot: '0,
                            total: total_r, count: count_r};
          case (in_data.cmd)
            cws_pkg::CMD_CLEAR: begin
              count_nxt          = '0;
              total_nxt          = '0;
              out_data_nxt.total = '0;
              out_data_nxt.count = '0;
            end
            cws_pkg::CMD_APPEND: begin
              if (count_r == COUNT_FULL) begin
                out_data_nxt.status = cws_pkg::STATUS_FULL;
              end else begin
                mem_we             = 1'b1;
                total_nxt          = sum_sat;
                count_nxt          = count_r + 1'b1;
                out_data_nxt.slot  = 6'(count_r);
                out_data_nxt.total = sum_sat;
                out_data_nxt.count = count_r + 1'b1;
              end
            end
            cws_pkg::CMD_SAMPLE: begin
              if (in_data.random > thr_r) begin
                out_data_nxt.status = cws_pkg::STATUS_STOP;
              end else if (count_r == '0) begin
                out_data_nxt.status = cws_pkg::STATUS_EMPTY;
              end else begin
                // result comes later from the search
                out_valid_nxt = out_stall ? out_valid_r : 1'b0;
                out_data_nxt  = out_data_r;
                rnd_nxt       = in_data.random;
                state_nxt     = ST_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt  = cws_pkg::PROD_BITS'(rnd_r) * cws_pkg::PROD_BITS'(total_r);
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          // zero threshold only gets here with random zero, whose target is zero
          target_nxt = (thr_r == '0) ? '0 : div_quo;
          lo_nxt     = '0;
          hi_nxt     = cws_pkg::SLOT_BITS'(count_r - 1'b1);
          state_nxt  = ST_SRCH;
        end
      end
      ST_SRCH: begin
        mem_re = 1'b1;
        if (lo_r < hi_r) begin
          rd_addr   = mid;
          state_nxt = ST_CMP;
        end else begin
          rd_addr   = lo_r;
          state_nxt = ST_FETCH;
        end
      end
      ST_CMP: begin
        if (target_r > rd_data_r.cum) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = ST_SRCH;
      end
      ST_FETCH: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: cws_pkg::STATUS_OK,
                            neighbor_out: rd_data_r.id,
                            slot: 6'(lo_r), total: total_r, count: count_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= cws_pkg::THR_RESET;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rnd_r      <= rnd_nxt;
    prod_r     <= prod_nxt;
    target_r   <= target_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("entry count beyond table depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH || state_r == ST_CMP) |->
      (lo_r <= hi_r) && ({1'b0, hi_r} < count_r))
    else $error("search window outside the held entries");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.cmd == cws_pkg::CMD_APPEND && count_r != COUNT_FULL) |=>
      (count_r == $past(count_r) + 1'b1))
    else $error("append did not add an entry");

  a_sample_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("sample result not delivered to the output register");

endmodule
`default_nettype wire

[src/cws_div.sv]
`default_nettype none
module cws_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [cws_pkg::PROD_BITS-1:0]      dividend,
  input  wire logic [cws_pkg::THR_BITS-1:0]       divisor,
  output logic                                    done,
  output logic [cws_pkg::QUO_BITS-1:0]            quotient
);

  localparam int CNT_BITS = $clog2(cws_pkg::QUO_BITS);
  localparam logic [CNT_BITS-1:0] STEP_LAST = CNT_BITS'(cws_pkg::QUO_BITS - 1);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [CNT_BITS-1:0]               cnt_r, cnt_nxt;
  logic [cws_pkg::THR_BITS:0]        rem_r, rem_nxt;
  logic [cws_pkg::QUO_BITS-1:0]      quo_r, quo_nxt;
  logic [cws_pkg::THR_BITS-1:0]      dvs_r, dvs_nxt;
  logic [cws_pkg::THR_BITS:0]        rem_sh;
  logic [cws_pkg::THR_BITS:0]        rem_sub;
  logic                              q_bit;

  // quotient never exceeds the total, so the upper dividend bits start as remainder
  always_comb begin
    rem_sh  = {rem_r[cws_pkg::THR_BITS-1:0], quo_r[cws_pkg::QUO_BITS-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    q_bit   = (rem_sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, dividend[cws_pkg::PROD_BITS-1:cws_pkg::QUO_BITS]};
      quo_nxt  = dividend[cws_pkg::QUO_BITS-1:0];
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = q_bit ? rem_sub : rem_sh;
      quo_nxt = {quo_r[cws_pkg::QUO_BITS-2:0], q_bit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cws_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [PADDR_BITS-1:0] THR_ADDR = PADDR_BITS'(4 * REG_THRESHOLD);
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [PADDR_BITS-1:0] cfg_paddr = '0;
  logic [PDATA_BITS-1:0] cfg_pwdata = '0;
  logic [PDATA_BITS-1:0] cfg_prdata;
  logic cfg_pready;

  // shadow of the sampler table and its threshold
  logic [TOTAL_BITS-1:0]   tbl_cum [DEPTH];
  logic [NODE_ID_BITS-1:0] tbl_nbr [DEPTH];
  logic [COUNT_BITS-1:0]   tbl_count = '0;
  logic [TOTAL_BITS-1:0]   tbl_total = '0;
  logic [THR_BITS-1:0]     thr_q = THR_RESET;

  out_rsp_t pending_rsp [$];

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_thr_writes = 0;
  int cmd_hits [4] = '{0, 0, 0, 0};
  int status_hits [4] = '{0, 0, 0, 0};

  cumulative_weight_sampler_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_rsp_t sampler_rsp(input in_req_t req);
    out_rsp_t rsp;
    logic [TOTAL_BITS:0] sum;
    logic [PROD_BITS-1:0] target;
    int lo;
    int hi;
    int mid;
    rsp = '0;
    case (req.cmd)
      CMD_CLEAR: begin
        tbl_count = '0;
        tbl_total = '0;
      end
      CMD_APPEND: begin
        if (tbl_count >= DEPTH) begin
          rsp.status = STATUS_FULL;
        end else begin
          sum = {1'b0, tbl_total} + {7'd0, req.weight};
          tbl_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
          tbl_cum[tbl_count] = tbl_total;
          tbl_nbr[tbl_count] = req.neighbor_in[NODE_ID_BITS-1:0];
          rsp.slot = tbl_count[SLOT_BITS-1:0];
          tbl_count = tbl_count + 1'b1;
        end
      end
      CMD_SAMPLE: begin
        // the stop test wins even over an empty table
        if (req.random > thr_q) begin
          rsp.status = STATUS_STOP;
        end else if (tbl_count == 0) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          if (thr_q == '0) target = '0;
          else target = (PROD_BITS'(req.random) * PROD_BITS'(tbl_total)) / PROD_BITS'(thr_q);
          lo = 0;
          hi = tbl_count - 1;
          // first entry whose cumulative weight reaches the target
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (target > PROD_BITS'(tbl_cum[mid])) lo = mid + 1;
            else hi = mid;
          end
          rsp.neighbor_out = tbl_nbr[lo];
          rsp.slot = lo[SLOT_BITS-1:0];
        end
      end
      default: ;
    endcase
    rsp.total = tbl_total;
    rsp.count = tbl_count;
    return rsp;
  endfunction

  function automatic in_req_t mk_req(input logic [1:0] cmd, input logic [15:0] nb,
                                     input logic [15:0] w, input logic [15:0] rnd);
    in_req_t req;
    req.cmd = cmd;
    req.neighbor_in = nb;
    req.weight = w;
    req.random = rnd;
    return req;
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_uniform();
    case ($urandom_range(11))
      0: return 16'h0000;
      1: return thr_q;
      2: return (thr_q == 16'hFFFF) ? thr_q : thr_q + 16'd1;
      3: return 16'hFFFF;
      4, 5: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(thr_q));
    endcase
  endfunction

  function automatic in_req_t append_req();
    return mk_req(CMD_APPEND, 16'($urandom_range(65535)), pick_weight(),
                  16'($urandom_range(65535)));
  endfunction

  function automatic in_req_t sample_req();
    return mk_req(CMD_SAMPLE, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  pick_uniform());
  endfunction

  function automatic in_req_t clear_req();
    return mk_req(CMD_CLEAR, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)));
  endfunction

  task automatic send_req(input in_req_t req);
    out_rsp_t rsp;
    int gap;
    if ($urandom_range(99) < snd_idle_pct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rsp = sampler_rsp(req);
    pending_rsp.insert(pending_rsp.size(), rsp);
    n_sent++;
    cmd_hits[req.cmd]++;
    status_hits[rsp.status]++;
  endtask

  // drop valid and pause until every outstanding response is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic write_threshold(input logic [THR_BITS-1:0] value);
    wait_idle();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= THR_ADDR;
    cfg_pwdata <= PDATA_BITS'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    thr_q = value;
    n_thr_writes++;
    // read back in a second transfer
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== PDATA_BITS'(value)) begin
      err_cnt++;
      $display("%0t: threshold readback expected %0h actual %0h", $time, value, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic note_field(input string name, input longint want, input longint got);
    err_cnt++;
    $display("%0t: response %0d %s expected %0h actual %0h", $time, n_checked, name, want,
             got);
  endtask

  task automatic check_rsp(input out_rsp_t got);
    out_rsp_t want;
    if (pending_rsp.size() == 0) begin
      err_cnt++;
      $display("%0t: response with no request outstanding, expected none actual %0h",
               $time, got);
      return;
    end
    want = pending_rsp.pop_front();
    n_checked++;
    if (got.status !== want.status) note_field("status", want.status, got.status);
    if (got.neighbor_out !== want.neighbor_out)
      note_field("neighbor_out", want.neighbor_out, got.neighbor_out);
    if (got.slot !== want.slot) note_field("slot", want.slot, got.slot);
    if (got.total !== want.total) note_field("total", want.total, got.total);
    if (got.count !== want.count) note_field("count", want.count, got.count);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_rsp(out_data);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: nothing moved on either channel for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic test_directed_cases();
    send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF));
    send_req(mk_req(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, thr_q + 16'd1));
    send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, thr_q));
    send_req(mk_req(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h0000));
    send_req(mk_req(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // zero weight entries around a maximum one
    send_req(mk_req(CMD_APPEND, 16'h0000, 16'h0000, 16'hFFFF));
    send_req(mk_req(CMD_APPEND, 16'hFFFF, 16'hFFFF, 16'h0000));
    send_req(mk_req(CMD_APPEND, 16'h1234, 16'h0000, 16'h5555));
    send_req(mk_req(CMD_APPEND, 16'h00FF, 16'h0001, 16'hAAAA));
    send_req(mk_req(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h0000));
    send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, thr_q));
    send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0001));
    send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, thr_q >> 1));
    send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF));
    send_req(mk_req(CMD_UNUSED, 16'h0000, 16'h0000, 16'h0000));
    send_req(mk_req(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000));
    send_req(mk_req(CMD_APPEND, 16'hA5A5, 16'hFFFF, 16'h0000));
    send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'd12345));
    send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, thr_q));
    send_req(mk_req(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000));
    wait_idle();
  endtask

  task automatic test_threshold_extremes();
    logic [THR_BITS-1:0] thr_list [5] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000, THR_RESET};
    foreach (thr_list[i]) begin
      write_threshold(thr_list[i]);
      send_req(clear_req());
      repeat (3) send_req(append_req());
      send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000));
      send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0001));
      send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, thr_q));
      send_req(mk_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF));
      repeat (3) send_req(sample_req());
    end
    wait_idle();
  endtask

  task automatic test_full_table();
    snd_idle_pct = 29;
    rcv_stall_pct = 29;
    send_req(clear_req());
    repeat (DEPTH) send_req(append_req());
    repeat (2) send_req(append_req());
    repeat (8) send_req(sample_req());
    wait_idle();
  endtask

  task automatic run_walk_traffic(input int n_items);
    int start;
    int pick;
    int len;
    start = n_sent;
    while (n_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        // noise: arbitrary requests, unused command included
        repeat ($urandom_range(1, 4))
          send_req(mk_req(2'($urandom_range(3)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535))));
      end else begin
        // a walk step: rebuild the list, then draw from it; some skip the clear
        if (pick < 90) send_req(clear_req());
        len = ($urandom_range(9) == 0) ? $urandom_range(56, 68) : $urandom_range(1, 12);
        repeat (len) send_req(append_req());
        repeat ($urandom_range(2, 16)) begin
          if ($urandom_range(7) == 0) send_req(append_req());
          else send_req(sample_req());
        end
        if ($urandom_range(49) == 0) wait_idle();
      end
    end
  endtask

  task automatic test_random_walks();
    int snd [4] = '{0, 55, 0, 29};
    int rcv [4] = '{0, 0, 55, 29};
    logic [THR_BITS-1:0] thr;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: thr = THR_RESET;
        2: thr = 16'hFFFF;
        default: thr = 16'($urandom_range(1, 65535));
      endcase
      write_threshold(thr);
      snd_idle_pct = snd[p];
      rcv_stall_pct = rcv[p];
      run_walk_traffic(400);
    end
    wait_idle();
  endtask

  task automatic test_receiver_hold();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    send_req(clear_req());
    repeat (4) send_req(append_req());
    // receiver backs off while requests keep coming
    hold_left = HOLD_CYCLES;
    repeat (12) begin
      if ($urandom_range(2) == 0) send_req(append_req());
      else send_req(sample_req());
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_threshold_extremes();
    test_full_table();
    test_random_walks();
    test_receiver_hold();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
    end
    $display("run: %0d requests (clear %0d, append %0d, sample %0d, unused %0d), %0d checked",
             n_sent, cmd_hits[CMD_CLEAR], cmd_hits[CMD_APPEND], cmd_hits[CMD_SAMPLE],
             cmd_hits[CMD_UNUSED], n_checked);
    $display("run: status ok %0d, stop %0d, empty %0d, full %0d; %0d threshold writes",
             status_hits[STATUS_OK], status_hits[STATUS_STOP], status_hits[STATUS_EMPTY],
             status_hits[STATUS_FULL], n_thr_writes);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
src/cws_pkg.sv
src/cws_div.sv
src/cumulative_weight_sampler_unit.sv
verif/tb.sv
